[rtl/core/bbr_pkg.sv]
// ----------------------------------------------------------------------------
// bbr_pkg
// Shared types and codes of the bilinear bound relaxation block: the input
// and result words, the per-neuron relaxation record and the register codes.
// ----------------------------------------------------------------------------
package bbr_pkg;

	// Field widths fixed by the word formats
	localparam int unsigned NEURON_W    = 10;
	localparam int unsigned SRC_W       = 10;
	localparam int unsigned ADDR_OUT_W  = 20;
	localparam int unsigned SIDE_W      = 2;
	localparam int unsigned TSIZE_W     = 11;
	localparam int unsigned CFG_INDEX_W = 1;
	localparam int unsigned CFG_DATA_W  = 11;

	// Configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_SIDE_SELECT = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_TARGET_SIZE = 1'b1;

	// Factor side codes
	localparam logic [SIDE_W-1:0] SIDE_FIRST  = 2'd0;
	localparam logic [SIDE_W-1:0] SIDE_SECOND = 2'd1;
	localparam logic [SIDE_W-1:0] SIDE_BOTH   = 2'd2;

	// Item kinds
	localparam logic KIND_BOUND  = 1'b0;
	localparam logic KIND_WEIGHT = 1'b1;

	typedef struct packed {
		logic                kind;
		logic [NEURON_W-1:0] neuron;
		logic [NEURON_W-1:0] index_a;
		logic [NEURON_W-1:0] index_b;
		logic signed [31:0]  val_lo_x;
		logic signed [31:0]  val_hi_x;
		logic signed [31:0]  lb_y;
		logic signed [31:0]  ub_y;
		logic signed [31:0]  prior_lb;
		logic signed [31:0]  prior_ub;
	} item_t;

	typedef struct packed {
		logic signed [31:0]    bound_lo;
		logic signed [31:0]    bound_hi;
		logic [ADDR_OUT_W-1:0] addr_a;
		logic signed [31:0]    lb_term_a;
		logic signed [31:0]    ub_term_a;
		logic [ADDR_OUT_W-1:0] addr_b;
		logic signed [31:0]    lb_term_b;
		logic signed [31:0]    ub_term_b;
		logic signed [31:0]    lower_bias_term;
		logic signed [31:0]    upper_bias_term;
	} result_t;

	// McCormick relaxation of one product neuron
	typedef struct packed {
		logic signed [31:0] lb_x;
		logic signed [31:0] lb_y;
		logic signed [31:0] ub_y;
		logic signed [31:0] low_bias;
		logic signed [31:0] up_bias;
		logic [SRC_W-1:0]   src_a;
		logic [SRC_W-1:0]   src_b;
	} nrec_t;

endpackage

[rtl/core/bbr_store.sv]
// ----------------------------------------------------------------------------
// bbr_store
// Per-neuron relaxation store: one synchronous memory with a registered read
// and one write port, plus forwarding of writes that the read missed.
// ----------------------------------------------------------------------------
module bbr_store #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned AW    = 10
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            rd_en,
	input  logic [AW-1:0]   rd_addr,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  bbr_pkg::nrec_t  wr_data,
	output bbr_pkg::nrec_t  rd_data
);
	import bbr_pkg::*;

	nrec_t         rec_mem [DEPTH];
	nrec_t         mem_rd_q;
	logic [AW-1:0] rd_addr_q;
	logic          lw_valid_q;
	logic [AW-1:0] lw_addr_q;
	nrec_t         lw_data_q;

	// Memory port: read on request, write back from the update stage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			rec_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			mem_rd_q  <= rec_mem[rd_addr];
			rd_addr_q <= rd_addr;
		end
	end

	// Hold the most recent write, which a read on the same edge did not see
	always_ff @(posedge clk) begin
		if (wr_en) begin
			lw_addr_q <= wr_addr;
			lw_data_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lw_valid_q <= 1'b0;
		end else if (wr_en) begin
			lw_valid_q <= 1'b1;
		end
	end

	// Forward: a write in flight wins over the held write, which wins over memory
	always_comb begin
		if (wr_en && (wr_addr == rd_addr_q)) begin
			rd_data = wr_data;
		end else if (lw_valid_q && (lw_addr_q == rd_addr_q)) begin
			rd_data = lw_data_q;
		end else begin
			rd_data = mem_rd_q;
		end
	end

endmodule

[rtl/core/bilinear_bound_relaxation_top.sv]
// ----------------------------------------------------------------------------
// bilinear_bound_relaxation_top
// Bound propagation and McCormick back-substitution for product neurons.
// ----------------------------------------------------------------------------
// The block takes one word per clock while the result side does not stall,
// and gives one result word per input word, in order, through the stage 1,
// stage 2, stage 3 and output registers. Throughput is one word per cycle,
// set by the read-modify-write of the per-neuron relaxation store: a word
// reads its neuron's record on acceptance, a bound word writes the new
// record as it leaves stage 2, and writes that a later read has not yet seen
// are forwarded, so a weight word may follow a bound word for the same neuron
// in the very next cycle. The stages are: store read and corner products,
// rounding with bounds and record write plus the weight products, rounding of
// the add terms, output register. No clearing pass runs after reset; a weight
// word for a neuron that no bound word has written yields undefined terms.
module bilinear_bound_relaxation_top #(
	parameter int unsigned MAX_NEURONS = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_ready,
	input  bbr_pkg::item_t                   item,
	output logic                             result_valid,
	input  logic                             result_ready,
	output bbr_pkg::result_t                 result,
	input  logic                             cfg_we,
	input  logic [bbr_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [bbr_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import bbr_pkg::*;

	localparam int unsigned AW      = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1;
	localparam int unsigned LO_BITS = 5;
	localparam int unsigned LO_N    = 2 ** LO_BITS;
	localparam int unsigned HI_N    = 2 ** (NEURON_W - LO_BITS);
	localparam logic [AW:0] DEPTH_C = (AW + 1)'(MAX_NEURONS);

	localparam logic signed [31:0] Q_MAX   = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q_MIN   = 32'sh8000_0000;
	localparam logic signed [47:0] Q_MAX48 = 48'sh0000_7FFF_FFFF;
	localparam logic signed [47:0] Q_MIN48 = 48'shFFFF_8000_0000;

	// Q16.16 product: optional negation, floor by 2^16, saturation
	function automatic logic signed [31:0] q_round_sat(input logic signed [63:0] p,
		input logic neg);
		logic signed [63:0] t;
		logic signed [47:0] s;
		t = neg ? -p : p;
		s = 48'(t >>> 16);
		if (s > Q_MAX48) begin
			return Q_MAX;
		end else if (s < Q_MIN48) begin
			return Q_MIN;
		end else begin
			return $signed(s[31:0]);
		end
	endfunction

	// Configuration
	logic [SIDE_W-1:0]  side_q;
	logic [TSIZE_W-1:0] tsize_q;

	// Handshake across the stages
	logic valid_s1, valid_s2, valid_s3, result_valid_q;
	logic free_out, free_s3, free_s2, free_s1;
	logic accept;

	// Stage 1
	item_t         item_s1;
	logic [AW-1:0] slot_s1;
	logic [AW-1:0] hi_tbl [HI_N];
	logic [AW-1:0] lo_tbl [LO_N];
	logic [AW:0]   slot_sum;
	logic [AW-1:0] slot;
	logic signed [63:0] corner [4];

	// Stage 2
	item_t              item_s2;
	logic [AW-1:0]      slot_s2;
	logic signed [63:0] corner_s2 [4];
	nrec_t              rec_s2;
	nrec_t              rd_rec;
	nrec_t              wr_rec;
	logic               wr_en;
	logic signed [31:0] cr [4];
	logic signed [31:0] c_min, c_max, bnd_lo, bnd_hi;
	logic signed [31:0] coef_lta, coef_uta, coef_lbias, coef_ubias;
	logic signed [63:0] term_p [6];
	logic [21:0]        addr_a_full, addr_b_full;

	// Stage 3
	logic                  kind_s3;
	logic signed [31:0]    bnd_lo_s3, bnd_hi_s3;
	logic [ADDR_OUT_W-1:0] addr_a_s3, addr_b_s3;
	logic signed [63:0]    term_s3 [6];
	logic                  use_a, use_b;
	result_t               result_d;
	result_t               result_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q  <= SIDE_BOTH;
			tsize_q <= TSIZE_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SIDE_SELECT: side_q  <= cfg_data[SIDE_W-1:0];
				REG_TARGET_SIZE: tsize_q <= cfg_data[TSIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// Ready chain: a stage takes a word when it is empty or moving on
	assign free_out   = !result_valid_q || result_ready;
	assign free_s3    = !valid_s3 || free_out;
	assign free_s2    = !valid_s2 || free_s3;
	assign free_s1    = !valid_s1 || free_s2;
	assign item_ready = free_s1;
	assign accept     = item_valid && free_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
			valid_s3       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (free_s1)  valid_s1       <= item_valid;
			if (free_s2)  valid_s2       <= valid_s1;
			if (free_s3)  valid_s3       <= valid_s2;
			if (free_out) result_valid_q <= valid_s3;
		end
	end

	// Fold the neuron index into the store depth: two small tables, one subtract
	for (genvar gi = 0; gi < HI_N; gi++) begin : g_hi_tbl
		assign hi_tbl[gi] = AW'((gi * LO_N) % MAX_NEURONS);
	end
	for (genvar gi = 0; gi < LO_N; gi++) begin : g_lo_tbl
		assign lo_tbl[gi] = AW'(gi % MAX_NEURONS);
	end

	assign slot_sum = {1'b0, hi_tbl[item.neuron[NEURON_W-1:LO_BITS]]}
		+ {1'b0, lo_tbl[item.neuron[LO_BITS-1:0]]};
	assign slot = (slot_sum >= DEPTH_C) ? AW'(slot_sum - DEPTH_C) : slot_sum[AW-1:0];

	// Relaxation store
	bbr_store #(
		.DEPTH (MAX_NEURONS),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (slot),
		.wr_en   (wr_en),
		.wr_addr (slot_s2),
		.wr_data (wr_rec),
		.rd_data (rd_rec)
	);

	// Stage 1: capture the word
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
			slot_s1 <= slot;
		end
	end

	// Corner products of the bound word
	assign corner[0] = 64'(item_s1.val_lo_x) * 64'(item_s1.lb_y);
	assign corner[1] = 64'(item_s1.val_lo_x) * 64'(item_s1.ub_y);
	assign corner[2] = 64'(item_s1.val_hi_x) * 64'(item_s1.lb_y);
	assign corner[3] = 64'(item_s1.val_hi_x) * 64'(item_s1.ub_y);

	// Advance into stage 2 with the forwarded record
	always_ff @(posedge clk) begin
		if (valid_s1 && free_s2) begin
			item_s2 <= item_s1;
			slot_s2 <= slot_s1;
			rec_s2  <= rd_rec;
			for (int k = 0; k < 4; k++) begin
				corner_s2[k] <= corner[k];
			end
		end
	end

	// Stage 2, bound word: round corners, take min and max, intersect
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			cr[k] = q_round_sat(corner_s2[k], 1'b0);
		end
		c_min = cr[0];
		c_max = cr[0];
		for (int k = 1; k < 4; k++) begin
			if (cr[k] < c_min) c_min = cr[k];
			if (cr[k] > c_max) c_max = cr[k];
		end
		bnd_lo = (item_s2.prior_lb > c_min) ? item_s2.prior_lb : c_min;
		bnd_hi = (item_s2.prior_ub < c_max) ? item_s2.prior_ub : c_max;
	end

	// Write back the relaxation record as the bound word leaves stage 2
	always_comb begin
		wr_rec.lb_x     = item_s2.val_lo_x;
		wr_rec.lb_y     = item_s2.lb_y;
		wr_rec.ub_y     = item_s2.ub_y;
		wr_rec.low_bias = q_round_sat(corner_s2[0], 1'b1);
		wr_rec.up_bias  = q_round_sat(corner_s2[1], 1'b1);
		wr_rec.src_a    = item_s2.index_a;
		wr_rec.src_b    = item_s2.index_b;
	end
	assign wr_en = valid_s2 && (item_s2.kind == KIND_BOUND) && free_s3;

	// Stage 2, weight word: pick coefficients by weight sign and multiply
	assign coef_lta   = item_s2.val_lo_x[31] ? rec_s2.ub_y     : rec_s2.lb_y;
	assign coef_uta   = item_s2.val_hi_x[31] ? rec_s2.lb_y     : rec_s2.ub_y;
	assign coef_lbias = item_s2.val_lo_x[31] ? rec_s2.up_bias  : rec_s2.low_bias;
	assign coef_ubias = item_s2.val_hi_x[31] ? rec_s2.low_bias : rec_s2.up_bias;

	assign term_p[0] = 64'(item_s2.val_lo_x) * 64'(coef_lta);
	assign term_p[1] = 64'(item_s2.val_hi_x) * 64'(coef_uta);
	assign term_p[2] = 64'(item_s2.val_lo_x) * 64'(rec_s2.lb_x);
	assign term_p[3] = 64'(item_s2.val_hi_x) * 64'(rec_s2.lb_x);
	assign term_p[4] = 64'(item_s2.val_lo_x) * 64'(coef_lbias);
	assign term_p[5] = 64'(item_s2.val_hi_x) * 64'(coef_ubias);

	assign addr_a_full = 22'(rec_s2.src_a) * 22'(tsize_q) + 22'(item_s2.index_a);
	assign addr_b_full = 22'(rec_s2.src_b) * 22'(tsize_q) + 22'(item_s2.index_a);

	// Advance into stage 3
	always_ff @(posedge clk) begin
		if (valid_s2 && free_s3) begin
			kind_s3   <= item_s2.kind;
			bnd_lo_s3 <= bnd_lo;
			bnd_hi_s3 <= bnd_hi;
			addr_a_s3 <= addr_a_full[ADDR_OUT_W-1:0];
			addr_b_s3 <= addr_b_full[ADDR_OUT_W-1:0];
			for (int k = 0; k < 6; k++) begin
				term_s3[k] <= term_p[k];
			end
		end
	end

	// Stage 3: round the add terms and drop unselected sides
	assign use_a = (side_q != SIDE_SECOND);
	assign use_b = (side_q != SIDE_FIRST);

	always_comb begin
		result_d = '0;
		if (kind_s3 == KIND_BOUND) begin
			result_d.bound_lo = bnd_lo_s3;
			result_d.bound_hi = bnd_hi_s3;
		end else begin
			if (use_a) begin
				result_d.addr_a    = addr_a_s3;
				result_d.lb_term_a = q_round_sat(term_s3[0], 1'b0);
				result_d.ub_term_a = q_round_sat(term_s3[1], 1'b0);
			end
			if (use_b) begin
				result_d.addr_b    = addr_b_s3;
				result_d.lb_term_b = q_round_sat(term_s3[2], 1'b0);
				result_d.ub_term_b = q_round_sat(term_s3[3], 1'b0);
			end
			result_d.lower_bias_term = q_round_sat(term_s3[4], 1'b0);
			result_d.upper_bias_term = q_round_sat(term_s3[5], 1'b0);
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (valid_s3 && free_out) begin
			result_q <= result_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
